@@ hdl/lesw_pkg.sv @@
// Shared types, constants and helpers for the line-edit scroll window unit.
// Depends on nothing; the top level and the checker import it.
package lesw_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int MAX_WINDOW_DEF = 32;
  localparam int RESULT_LIMIT   = 32;
  localparam int WIDTH_W        = 6;
  localparam int RENDER_W       = 8;
  localparam int LENGTH_W       = 7;
  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 6'd5;

  localparam logic [7:0] CH_CURSOR  = 8'h5F;
  localparam logic [7:0] CH_HIDDEN  = 8'h2E;
  localparam logic [7:0] CH_PAST    = 8'h24;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_CAP_LO  = 8'h41;
  localparam logic [7:0] CH_CAP_HI  = 8'h5A;

  typedef enum logic [2:0] {
    OP_LEFT   = 3'd0,
    OP_START  = 3'd1,
    OP_RIGHT  = 3'd2,
    OP_END    = 3'd3,
    OP_DELETE = 3'd4,
    OP_INSERT = 3'd5,
    OP_SHOW   = 3'd6,
    OP_NOP    = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_DEL,
    S_UPD,
    S_FIN,
    S_SHOW
  } state_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] char_in;
  } cmd_t;

  typedef struct packed {
    logic [7:0]          screen_char;
    logic [4:0]          cursor_cell;
    logic [7:0]          window_first;
    logic [LENGTH_W-1:0] text_length;
    logic                accepted;
    logic                last;
  } result_t;

  function automatic logic is_capital(input logic [7:0] c);
    return (c >= CH_CAP_LO) && (c <= CH_CAP_HI);
  endfunction

endpackage

@@ hdl/line_edit_scroll_window_unit.sv @@
// Line-edit buffer with a scrolling display window, top level.
// Depends on lesw_pkg and lesw_ram.
//
// Usage. A command word (opcode, char_in) is taken at a clock edge where
// start is high and busy is low. Results leave on the result port, each
// valid for exactly one cycle while result_valid is high; the receiver
// cannot stall them. Every command gives one result word, except show,
// which gives one word per window cell with last set on the final one; no
// word leaves while the walk steps on to the next character. The window
// width register is written on its own channel (cfg_valid, cfg_ready,
// cfg_data); cfg_ready is always high and a new width takes effect at
// once, also on a command that is running.
//
// Sequencing. A refused insert or a no-operation gives its word in the next
// cycle. Every other command walks the text store one entry per cycle
// through the single read port of the text RAM, except that show holds the
// walk while it gives a word. Delete and insert first shift the characters
// behind the cursor by one entry; moves, delete and insert then walk the
// whole text to find the render positions and scroll the window, and show
// walks the text and the window cells together. busy stays high throughout.
//
// Reset (synchronous, active high) empties the buffer, homes the cursor
// and the window and sets the width to five cells. The text RAM itself is
// not cleared: entries past the text length are never read for output.
module line_edit_scroll_window_unit
  import lesw_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  cmd_t               cmd,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [WIDTH_W-1:0] cfg_data,
  output logic               result_valid,
  output result_t            result
);

  localparam int CW = $clog2(CAPACITY + 1);   // counts up to CAPACITY
  localparam int AW = $clog2(CAPACITY);       // addresses into the store
  localparam int MW = (MAX_WINDOW < RESULT_LIMIT) ? MAX_WINDOW : RESULT_LIMIT;
  localparam logic [WIDTH_W-1:0] WMAX = WIDTH_W'(MW);
  localparam logic [WIDTH_W-1:0] WMIN = WIDTH_W'(2);

  state_t state, state_next;

  // Architectural state.
  logic [CW-1:0]       count, count_next;
  logic [CW-1:0]       cursor, cursor_next;
  logic [RENDER_W-1:0] cursor_render, cursor_render_next;
  logic [RENDER_W-1:0] render_length, render_length_next;
  logic [RENDER_W-1:0] origin, origin_next;
  logic [WIDTH_W-1:0]  window_width;

  // Sequencer working registers.
  logic [CW-1:0]       ti, ti_next;       // text index being walked
  logic [RENDER_W-1:0] rp, rp_next;       // render position of text[ti]
  logic [RENDER_W-1:0] at, at_next;       // render position of the cursor
  logic [4:0]          p, p_next;         // window cell being shown
  logic [7:0]          ins_char;

  result_t result_next;
  logic    result_valid_next;

  // Text RAM port.
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic [AW-1:0] raddr;
  logic [7:0]    rdata;

  lesw_ram #(.WIDTH(8), .DEPTH(CAPACITY)) u_text (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Width actually used, clamped to 2 .. MW.
  logic [WIDTH_W-1:0] wuse;
  always_comb begin
    if (window_width < WMIN) begin
      wuse = WMIN;
    end else if (window_width > WMAX) begin
      wuse = WMAX;
    end else begin
      wuse = window_width;
    end
  end

  // Shared decisions used by both the next-state and the datapath logic.
  op_t                 op;
  logic                ins_refused;
  logic                ti_lt_count;
  logic                ti_gt_cursor;
  logic [RENDER_W-1:0] cw;
  logic [8:0]          idx;
  logic                idx_in_text;
  logic                show_skip;
  logic                show_last;

  assign op           = op_t'(cmd.opcode);
  assign ins_refused  = (count >= CW'(CAPACITY)) || (cmd.char_in == CH_NEWLINE);
  assign ti_lt_count  = ti < count;
  assign ti_gt_cursor = ti > cursor;
  assign cw           = is_capital(rdata) ? RENDER_W'(2) : RENDER_W'(1);
  assign idx          = 9'(origin) + 9'(p);
  assign idx_in_text  = idx < 9'(render_length);
  assign show_skip    = idx_in_text && ((9'(rp) + 9'(cw)) <= idx);
  assign show_last    = (WIDTH_W'(p) == wuse - WIDTH_W'(1));

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (op)
            OP_LEFT, OP_START, OP_RIGHT, OP_END: state_next = S_UPD;
            OP_DELETE: state_next = (cursor != '0) ? S_DEL : S_UPD;
            OP_INSERT: state_next = ins_refused ? S_IDLE : S_INS;
            OP_SHOW:   state_next = S_SHOW;
            OP_NOP:    state_next = S_IDLE;
          endcase
        end
      end
      S_INS:  state_next = ti_gt_cursor ? S_INS : S_UPD;
      S_DEL:  state_next = ti_lt_count ? S_DEL : S_UPD;
      S_UPD:  state_next = ti_lt_count ? S_UPD : S_FIN;
      S_FIN:  state_next = S_IDLE;
      S_SHOW: state_next = (!show_skip && show_last) ? S_IDLE : S_SHOW;
      default: state_next = S_IDLE;
    endcase
  end

  // Window scroll, evaluated at the end of the render walk.
  logic [RENDER_W-1:0] cr_final;
  logic [9:0]          ne;
  logic [RENDER_W-1:0] origin_scrolled;
  always_comb begin
    cr_final = (cursor >= count) ? rp : at;
    ne = (cr_final == rp) ? (10'(cr_final) + 10'd1) : (10'(cr_final) + 10'd2);
    origin_scrolled = origin;
    if (cr_final <= origin) begin
      origin_scrolled = (cr_final == '0) ? '0 : cr_final - RENDER_W'(1);
    end else if ((10'(origin) + 10'(wuse) - 10'd1) <= 10'(cr_final)) begin
      origin_scrolled = (ne > 10'(wuse)) ? RENDER_W'(ne - 10'(wuse)) : '0;
    end
  end

  // Result word built from the current registers.
  function automatic result_t make_result(input logic [7:0] ch, input logic acc,
                                          input logic lst);
    result_t r;
    r.screen_char  = ch;
    r.cursor_cell  = 5'(cursor_render - origin);
    r.window_first = origin;
    r.text_length  = LENGTH_W'(count);
    r.accepted     = acc;
    r.last         = lst;
    return r;
  endfunction

  // Datapath and outputs.
  logic [7:0] show_char;
  always_comb begin
    if (idx == 9'(cursor_render)) begin
      show_char = CH_CURSOR;
    end else if (idx_in_text) begin
      if ((p == '0) && (idx != '0)) begin
        show_char = CH_HIDDEN;
      end else if (show_last && (idx != (9'(render_length) - 9'd1))) begin
        show_char = CH_HIDDEN;
      end else begin
        show_char = rdata;
      end
    end else begin
      show_char = CH_PAST;
    end
  end

  always_comb begin
    count_next         = count;
    cursor_next        = cursor;
    cursor_render_next = cursor_render;
    render_length_next = render_length;
    origin_next        = origin;
    ti_next            = ti;
    rp_next            = rp;
    at_next            = at;
    p_next             = p;
    we                 = 1'b0;
    waddr              = AW'(ti);
    wdata              = rdata;
    result_valid_next  = 1'b0;
    result_next        = result;

    unique case (state)
      S_IDLE: begin
        ti_next = '0;
        rp_next = '0;
        at_next = '0;
        p_next  = '0;
        if (start) begin
          unique case (op)
            OP_LEFT: begin
              if (cursor != '0) begin
                cursor_next = cursor - CW'(1);
              end
            end
            OP_START: cursor_next = '0;
            OP_RIGHT: begin
              if (cursor < count) begin
                cursor_next = cursor + CW'(1);
              end
            end
            OP_END: cursor_next = count;
            OP_DELETE: begin
              if (cursor != '0) begin
                ti_next = cursor;
              end
            end
            OP_INSERT: begin
              if (ins_refused) begin
                result_valid_next = 1'b1;
                result_next       = make_result(8'h00, 1'b0, 1'b1);
              end else begin
                ti_next = count;
              end
            end
            OP_SHOW: ;
            OP_NOP: begin
              result_valid_next = 1'b1;
              result_next       = make_result(8'h00, 1'b0, 1'b1);
            end
          endcase
        end
      end

      S_INS: begin
        we = 1'b1;
        if (ti_gt_cursor) begin
          // Move text[ti-1] up into text[ti].
          waddr   = AW'(ti);
          wdata   = rdata;
          ti_next = ti - CW'(1);
        end else begin
          waddr       = AW'(cursor);
          wdata       = ins_char;
          count_next  = count + CW'(1);
          cursor_next = cursor + CW'(1);
          ti_next     = '0;
          rp_next     = '0;
          at_next     = '0;
        end
      end

      S_DEL: begin
        if (ti_lt_count) begin
          // Move text[ti] down into text[ti-1].
          we      = 1'b1;
          waddr   = AW'(ti - CW'(1));
          wdata   = rdata;
          ti_next = ti + CW'(1);
        end else begin
          count_next  = count - CW'(1);
          cursor_next = cursor - CW'(1);
          ti_next     = '0;
          rp_next     = '0;
          at_next     = '0;
        end
      end

      S_UPD: begin
        if (ti_lt_count) begin
          if (ti == cursor) begin
            at_next = rp;
          end
          rp_next = rp + cw;
          ti_next = ti + CW'(1);
        end else begin
          cursor_render_next = cr_final;
          render_length_next = rp;
          origin_next        = origin_scrolled;
        end
      end

      S_FIN: begin
        result_valid_next = 1'b1;
        result_next       = make_result(8'h00, 1'b1, 1'b1);
      end

      S_SHOW: begin
        if (show_skip) begin
          rp_next = rp + cw;
          ti_next = ti + CW'(1);
        end else begin
          result_valid_next = 1'b1;
          result_next       = make_result(show_char, 1'b1, show_last);
          p_next            = p + 5'd1;
        end
      end

      default: ;
    endcase

    // The insert walk reads one entry below the one it writes next.
    if (state_next == S_INS) begin
      raddr = AW'(ti_next - CW'(1));
    end else begin
      raddr = AW'(ti_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      cursor        <= '0;
      cursor_render <= '0;
      render_length <= '0;
      origin        <= '0;
      window_width  <= WIDTH_RESET;
      result_valid  <= 1'b0;
    end else begin
      state         <= state_next;
      count         <= count_next;
      cursor        <= cursor_next;
      cursor_render <= cursor_render_next;
      render_length <= render_length_next;
      origin        <= origin_next;
      result_valid  <= result_valid_next;
      if (cfg_valid && cfg_ready) begin
        window_width <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    ti     <= ti_next;
    rp     <= rp_next;
    at     <= at_next;
    p      <= p_next;
    result <= result_next;
    if ((state == S_IDLE) && start) begin
      ins_char <= cmd.char_in;
    end
  end

endmodule

@@ hdl/lesw_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// A read of the address being written in the same cycle returns the new data.
// Depends on nothing.
module lesw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/lesw_checker.sv @@
// Port-level checks for the line-edit scroll window unit, bound to its top.
// Depends on lesw_pkg and line_edit_scroll_window_unit.
module lesw_checker
  import lesw_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input logic    result_valid,
  input result_t result
);

  // A show burst keeps the unit busy until its last word.
  a_burst_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last |-> busy)
    else $error("unit free before the last word of a show burst");

  // An accepted command either keeps the unit busy or answers at once.
  a_accept_answered: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || result_valid)
    else $error("command accepted but neither busy nor answered");

  // The final word of a command coincides with the unit being free again.
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last |-> !busy)
    else $error("busy still high on the last word of a command");

  // Only a single-word answer may be a refusal.
  a_refusal_single: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.accepted |-> result.last && result.screen_char == 8'h00)
    else $error("refused command produced a multi-word or show answer");

endmodule

bind line_edit_scroll_window_unit lesw_checker u_lesw_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .result       (result)
);
